[design/assert_macros.svh]
// Assertion macros used by the arithmetic pipeline (tnac_back).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, pre, post)
`define ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

[design/tnac_pkg.sv]
// Shared constants for the triangle normal, area and centroid block.
package tnac_pkg;
   localparam int COORD_WIDTH_DEF      = 24;
   localparam int NORMAL_FRAC_BITS_DEF = 15;
   localparam int AREA_WIDTH           = 50;
   localparam int QUEUE_DEPTH          = 4;
endpackage

[design/tnac_front.sv]
// Front stage: accepts a triangle and forms its edge vectors and biased vertex sums.
module tnac_front #(
   parameter int CW = tnac_pkg::COORD_WIDTH_DEF,
   localparam int QDW = 6 * (CW + 1) + 3 * (CW + 3) + 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic signed [CW-1:0] req_vertex_a_x,
   input  logic signed [CW-1:0] req_vertex_a_y,
   input  logic signed [CW-1:0] req_vertex_a_z,
   input  logic signed [CW-1:0] req_vertex_b_x,
   input  logic signed [CW-1:0] req_vertex_b_y,
   input  logic signed [CW-1:0] req_vertex_b_z,
   input  logic signed [CW-1:0] req_vertex_c_x,
   input  logic signed [CW-1:0] req_vertex_c_y,
   input  logic signed [CW-1:0] req_vertex_c_z,
   input  logic                 req_last_in_mesh,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic [QDW-1:0]       out_data
);
   localparam int EW = CW + 1;
   localparam int UW = CW + 3;
   localparam logic [UW-1:0] BIAS = (UW'(3) << CW) + UW'(1);

   typedef struct packed {
      logic signed [EW-1:0] ux, uy, uz, vx, vy, vz;
      logic [UW-1:0]        sx, sy, sz;
      logic                 last;
   } qitem_type;

   qitem_type item_in;
   logic      vld_ff;
   logic [QDW-1:0] data_ff;

   always_comb begin
      item_in.ux   = EW'(req_vertex_b_x) - EW'(req_vertex_a_x);
      item_in.uy   = EW'(req_vertex_b_y) - EW'(req_vertex_a_y);
      item_in.uz   = EW'(req_vertex_b_z) - EW'(req_vertex_a_z);
      item_in.vx   = EW'(req_vertex_c_x) - EW'(req_vertex_a_x);
      item_in.vy   = EW'(req_vertex_c_y) - EW'(req_vertex_a_y);
      item_in.vz   = EW'(req_vertex_c_z) - EW'(req_vertex_a_z);
      item_in.sx   = UW'(req_vertex_a_x) + UW'(req_vertex_b_x) + UW'(req_vertex_c_x) + BIAS;
      item_in.sy   = UW'(req_vertex_a_y) + UW'(req_vertex_b_y) + UW'(req_vertex_c_y) + BIAS;
      item_in.sz   = UW'(req_vertex_a_z) + UW'(req_vertex_b_z) + UW'(req_vertex_c_z) + BIAS;
      item_in.last = req_last_in_mesh;
   end

   assign req_ready = !vld_ff || out_ready;
   assign out_valid = vld_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (req_ready) begin
         vld_ff <= req_valid;
      end
      if (req_ready && req_valid) begin
         data_ff <= item_in;
      end
   end
endmodule

[design/tnac_queue.sv]
// Short queue that decouples the front stage from the arithmetic pipeline.
module tnac_queue #(
   parameter int DW = 8
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  logic [DW-1:0] in_data,
   output logic          out_valid,
   input  logic          out_ready,
   output logic [DW-1:0] out_data
);
   localparam int DEPTH = tnac_pkg::QUEUE_DEPTH;
   localparam int AW    = $clog2(DEPTH);
   localparam int CNTW  = AW + 1;

   logic [DW-1:0]   mem_ff [DEPTH];
   logic [AW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CNTW-1:0] count_ff, count_in;
   logic            push, pop;

   assign in_ready  = count_ff != CNTW'(DEPTH);
   assign out_valid = count_ff != '0;
   assign out_data  = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      count_in = count_ff + CNTW'(push) - CNTW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + AW'(1);
         if (pop) rd_ptr_ff <= rd_ptr_ff + AW'(1);
         count_ff <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_data;
      end
   end
endmodule

[design/tnac_back.sv]
// Arithmetic pipeline: cross product, square root, normal division and centroid.
`include "assert_macros.svh"
module tnac_back #(
   parameter int CW = tnac_pkg::COORD_WIDTH_DEF,
   parameter int NF = tnac_pkg::NORMAL_FRAC_BITS_DEF,
   localparam int QDW = 6 * (CW + 1) + 3 * (CW + 3) + 1
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  logic [QDW-1:0]                      in_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [NF:0]                  rsp_normal_x,
   output logic signed [NF:0]                  rsp_normal_y,
   output logic signed [NF:0]                  rsp_normal_z,
   output logic [tnac_pkg::AREA_WIDTH-1:0]     rsp_double_area,
   output logic signed [CW-1:0]                rsp_centroid_x,
   output logic signed [CW-1:0]                rsp_centroid_y,
   output logic signed [CW-1:0]                rsp_centroid_z,
   output logic                                rsp_degenerate,
   output logic                                rsp_last_out
);
   localparam int EW  = CW + 1;
   localparam int UW  = CW + 3;
   localparam int PW  = 2 * EW;
   localparam int XW  = PW + 1;
   localparam int MW  = PW;
   localparam int LO  = MW / 2;
   localparam int HI  = MW - LO;
   localparam int SW  = 2 * MW;
   localparam int RW  = MW;
   localparam int LW  = RW + 1;
   localparam int QW  = NF + 1;
   localparam int NW  = NF + 1;
   localparam int SDW = 3 * CW + 1;
   localparam int AW  = tnac_pkg::AREA_WIDTH;
   localparam int AXW = (LW > AW) ? LW : AW;
   localparam int CMW = 2 * UW - 1;
   localparam logic [UW-2:0] RECIP = (UW-1)'((64'd1 << UW) / 64'd3);

   typedef struct packed {
      logic signed [EW-1:0] ux, uy, uz, vx, vy, vz;
      logic [UW-1:0]        sx, sy, sz;
      logic                 last;
   } qitem_type;

   typedef struct packed {
      logic [2:0][MW-1:0] mag;
      logic [2:0]         sgn;
      logic [SDW-1:0]     side;
   } sc_type;

   typedef struct packed {
      logic [LW-1:0] rem;
      logic [QW-1:0] q;
   } dv_type;

   typedef struct packed {
      logic [LW-1:0]  len;
      logic [2:0]     sgn;
      logic [SDW-1:0] side;
   } hold_type;

   qitem_type item;
   logic      en;
   logic      rsp_valid_ff;

   assign item     = in_data;
   assign en       = !rsp_valid_ff || rsp_ready;
   assign in_ready = en;

   // Stage A: cross product terms and centroid reciprocal products.
   logic                 a_vld_ff;
   logic signed [PW-1:0] a_prod_in [6];
   logic signed [PW-1:0] a_prod_ff [6];
   logic [UW-1:0]        a_u [3];
   logic [UW-1:0]        a_u_ff [3];
   logic [CMW-1:0]       a_cm_in [3];
   logic [CMW-1:0]       a_cm_ff [3];
   logic                 a_last_ff;

   always_comb begin
      a_prod_in[0] = item.uy * item.vz;
      a_prod_in[1] = item.uz * item.vy;
      a_prod_in[2] = item.uz * item.vx;
      a_prod_in[3] = item.ux * item.vz;
      a_prod_in[4] = item.ux * item.vy;
      a_prod_in[5] = item.uy * item.vx;
      a_u[0] = item.sx;
      a_u[1] = item.sy;
      a_u[2] = item.sz;
      for (int i = 0; i < 3; i++) begin
         a_cm_in[i] = CMW'(a_u[i]) * CMW'(RECIP);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) a_vld_ff <= 1'b0;
      else if (en) a_vld_ff <= in_valid;
      if (en) begin
         a_prod_ff <= a_prod_in;
         a_u_ff    <= a_u;
         a_cm_ff   <= a_cm_in;
         a_last_ff <= item.last;
      end
   end

   // Stage B: cross product components and corrected centroid.
   logic                 b_vld_ff;
   logic signed [XW-1:0] b_x_in [3];
   logic signed [XW-1:0] b_x_ff [3];
   logic [SDW-1:0]       b_side_in, b_side_ff;
   logic [UW-2:0]        b_q0 [3];
   logic [UW-2:0]        b_cq [3];
   logic [UW:0]          b_r [3];

   always_comb begin
      b_x_in[0] = XW'(a_prod_ff[0]) - XW'(a_prod_ff[1]);
      b_x_in[1] = XW'(a_prod_ff[2]) - XW'(a_prod_ff[3]);
      b_x_in[2] = XW'(a_prod_ff[4]) - XW'(a_prod_ff[5]);
      for (int i = 0; i < 3; i++) begin
         b_q0[i] = a_cm_ff[i][CMW-1:UW];
         b_r[i]  = (UW+1)'(a_u_ff[i]) - ((UW+1)'(b_q0[i]) + ((UW+1)'(b_q0[i]) << 1));
         b_cq[i] = b_q0[i] + (UW-1)'(b_r[i] >= (UW+1)'(3));
      end
      b_side_in = {b_cq[0][CW-1:0], b_cq[1][CW-1:0], b_cq[2][CW-1:0], a_last_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) b_vld_ff <= 1'b0;
      else if (en) b_vld_ff <= a_vld_ff;
      if (en) begin
         b_x_ff    <= b_x_in;
         b_side_ff <= b_side_in;
      end
   end

   // Stage C: magnitudes and partial products of the squares.
   logic                c_vld_ff;
   sc_type              c_c_in, c_c_ff;
   logic [2*HI-1:0]     c_hh_in [3];
   logic [2*HI-1:0]     c_hh_ff [3];
   logic [HI+LO-1:0]    c_hl_in [3];
   logic [HI+LO-1:0]    c_hl_ff [3];
   logic [2*LO-1:0]     c_ll_in [3];
   logic [2*LO-1:0]     c_ll_ff [3];
   logic [XW-1:0]       c_abs [3];

   always_comb begin
      c_c_in.side = b_side_ff;
      for (int i = 0; i < 3; i++) begin
         c_c_in.sgn[i] = b_x_ff[i][XW-1];
         c_abs[i]      = b_x_ff[i][XW-1] ? -b_x_ff[i] : b_x_ff[i];
         c_c_in.mag[i] = c_abs[i][MW-1:0];
         c_hh_in[i] = (2*HI)'(c_abs[i][MW-1:LO]) * (2*HI)'(c_abs[i][MW-1:LO]);
         c_hl_in[i] = (HI+LO)'(c_abs[i][MW-1:LO]) * (HI+LO)'(c_abs[i][LO-1:0]);
         c_ll_in[i] = (2*LO)'(c_abs[i][LO-1:0]) * (2*LO)'(c_abs[i][LO-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) c_vld_ff <= 1'b0;
      else if (en) c_vld_ff <= b_vld_ff;
      if (en) begin
         c_c_ff  <= c_c_in;
         c_hh_ff <= c_hh_in;
         c_hl_ff <= c_hl_in;
         c_ll_ff <= c_ll_in;
      end
   end

   // Stage D: squares of the components.
   logic          d_vld_ff;
   sc_type        d_c_ff;
   logic [SW-1:0] d_sq_in [3];
   logic [SW-1:0] d_sq_ff [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         d_sq_in[i] = (SW'(c_hh_ff[i]) << (2 * LO)) + (SW'(c_hl_ff[i]) << (LO + 1))
                      + SW'(c_ll_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) d_vld_ff <= 1'b0;
      else if (en) d_vld_ff <= c_vld_ff;
      if (en) begin
         d_c_ff  <= c_c_ff;
         d_sq_ff <= d_sq_in;
      end
   end

   // Stage E and square root pipeline, one root bit per stage.
   logic          sr_vld_ff  [RW+1];
   logic [RW+1:0] sr_rem_ff  [RW+1];
   logic [RW-1:0] sr_root_ff [RW+1];
   logic [SW-1:0] sr_s_ff    [RW+1];
   sc_type        sr_c_ff    [RW+1];

   always_ff @(posedge clock) begin
      if (reset) sr_vld_ff[0] <= 1'b0;
      else if (en) sr_vld_ff[0] <= d_vld_ff;
      if (en) begin
         sr_rem_ff[0]  <= '0;
         sr_root_ff[0] <= '0;
         sr_s_ff[0]    <= d_sq_ff[0] + d_sq_ff[1] + d_sq_ff[2];
         sr_c_ff[0]    <= d_c_ff;
      end
   end

   for (genvar k = 0; k < RW; k++) begin : g_sqrt
      logic [RW+2:0] rem4, trial;
      logic          ge;
      logic [RW+2:0] diff;
      logic [RW+1:0] rem_in;
      logic [RW-1:0] root_in;

      always_comb begin
         rem4    = {sr_rem_ff[k][RW:0], sr_s_ff[k][SW-1 -: 2]};
         trial   = (RW+3)'({sr_root_ff[k], 2'b01});
         ge      = rem4 >= trial;
         diff    = ge ? (rem4 - trial) : rem4;
         rem_in  = diff[RW+1:0];
         root_in = {sr_root_ff[k][RW-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) sr_vld_ff[k+1] <= 1'b0;
         else if (en) sr_vld_ff[k+1] <= sr_vld_ff[k];
         if (en) begin
            sr_rem_ff[k+1]  <= rem_in;
            sr_root_ff[k+1] <= root_in;
            sr_s_ff[k+1]    <= sr_s_ff[k] << 2;
            sr_c_ff[k+1]    <= sr_c_ff[k];
         end
      end
   end

   // Rounding of the length and divider pipeline, one quotient bit per stage.
   logic     dv_vld_ff [QW+1];
   dv_type   dv_ff     [QW+1][3];
   hold_type dh_ff     [QW+1];
   hold_type r_h_in;
   dv_type   r_dv_in [3];

   always_comb begin
      r_h_in.len  = LW'(sr_root_ff[RW])
                    + LW'(sr_rem_ff[RW] > (RW+2)'(sr_root_ff[RW]));
      r_h_in.sgn  = sr_c_ff[RW].sgn;
      r_h_in.side = sr_c_ff[RW].side;
      for (int i = 0; i < 3; i++) begin
         r_dv_in[i].rem = LW'(sr_c_ff[RW].mag[i]);
         r_dv_in[i].q   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) dv_vld_ff[0] <= 1'b0;
      else if (en) dv_vld_ff[0] <= sr_vld_ff[RW];
      if (en) begin
         dh_ff[0] <= r_h_in;
         dv_ff[0] <= r_dv_in;
      end
   end

   for (genvar k = 0; k < QW; k++) begin : g_div
      logic [LW:0] r_in [3];
      logic [LW:0] d_in [3];
      logic        ge [3];
      dv_type      dv_in [3];

      always_comb begin
         for (int i = 0; i < 3; i++) begin
            r_in[i] = (k == 0) ? (LW+1)'(dv_ff[k][i].rem) : {dv_ff[k][i].rem, 1'b0};
            ge[i]   = r_in[i] >= (LW+1)'(dh_ff[k].len);
            d_in[i] = ge[i] ? (r_in[i] - (LW+1)'(dh_ff[k].len)) : r_in[i];
            dv_in[i].rem = d_in[i][LW-1:0];
            dv_in[i].q   = {dv_ff[k][i].q[QW-2:0], ge[i]};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) dv_vld_ff[k+1] <= 1'b0;
         else if (en) dv_vld_ff[k+1] <= dv_vld_ff[k];
         if (en) begin
            dh_ff[k+1] <= dh_ff[k];
            dv_ff[k+1] <= dv_in;
         end
      end
   end

   // Output register: rounding, saturation and area clamp.
   function automatic logic [NW-1:0] norm_sat(logic [QW-1:0] q, logic rnd, logic neg);
      logic [QW:0] qr;
      logic [QW:0] lim;
      logic [QW:0] qs;
      qr  = (QW+1)'(q) + (QW+1)'(rnd);
      lim = (QW+1)'(1) << NF;
      if (neg) begin
         qs = (qr > lim) ? lim : qr;
         qs = -qs;
      end else begin
         qs = (qr > lim - (QW+1)'(1)) ? lim - (QW+1)'(1) : qr;
      end
      return qs[NW-1:0];
   endfunction

   logic [NW-1:0]        o_n_in [3];
   logic [NW-1:0]        rsp_normal_x_ff, rsp_normal_y_ff, rsp_normal_z_ff;
   logic [AXW-1:0]       o_lenx;
   logic [AW-1:0]        o_area_in, rsp_double_area_ff;
   logic                 o_degen_in, rsp_degenerate_ff;
   logic [SDW-1:0]       rsp_side_ff;
   logic                 o_rnd [3];

   always_comb begin
      o_degen_in = dh_ff[QW].len == '0;
      for (int i = 0; i < 3; i++) begin
         o_rnd[i]  = {dv_ff[QW][i].rem, 1'b0} >= (LW+1)'(dh_ff[QW].len);
         o_n_in[i] = o_degen_in ? '0
                     : norm_sat(dv_ff[QW][i].q, o_rnd[i], dh_ff[QW].sgn[i]);
      end
      o_lenx    = AXW'(dh_ff[QW].len);
      o_area_in = (o_lenx > AXW'({AW{1'b1}})) ? {AW{1'b1}} : o_lenx[AW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (en) rsp_valid_ff <= dv_vld_ff[QW];
      if (en) begin
         rsp_normal_x_ff    <= o_n_in[0];
         rsp_normal_y_ff    <= o_n_in[1];
         rsp_normal_z_ff    <= o_n_in[2];
         rsp_double_area_ff <= o_area_in;
         rsp_degenerate_ff  <= o_degen_in;
         rsp_side_ff        <= dh_ff[QW].side;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_normal_x    = rsp_normal_x_ff;
   assign rsp_normal_y    = rsp_normal_y_ff;
   assign rsp_normal_z    = rsp_normal_z_ff;
   assign rsp_double_area = rsp_double_area_ff;
   assign rsp_degenerate  = rsp_degenerate_ff;
   assign rsp_centroid_x  = rsp_side_ff[SDW-1 -: CW];
   assign rsp_centroid_y  = rsp_side_ff[SDW-1-CW -: CW];
   assign rsp_centroid_z  = rsp_side_ff[CW:1];
   assign rsp_last_out    = rsp_side_ff[0];

   `ASSERT_IMPLIES(a_degen_zero_normal, clock, reset, rsp_valid_ff && rsp_degenerate_ff, (rsp_normal_x_ff == '0) && (rsp_normal_y_ff == '0) && (rsp_normal_z_ff == '0))
   `ASSERT_IMPLIES(a_degen_area, clock, reset, rsp_valid_ff, rsp_degenerate_ff == (rsp_double_area_ff == '0))
   `ASSERT_NEXT(a_stall_hold, clock, reset, rsp_valid_ff && !rsp_ready, rsp_valid_ff && $stable(rsp_double_area_ff) && $stable(rsp_side_ff))
endmodule

[design/triangle_normal_area_centroid.sv]
// Top level of the triangle face normal, double area and centroid block.
// One triangle (three signed fixed-point vertices and a last-in-mesh marker)
// is taken on the req_ channel per valid/ready transfer, and exactly one
// result (unit normal, double area, centroid, degenerate flag, marker) leaves
// on the rsp_ channel per transfer, in the same order.
// The block takes a new triangle every cycle while the receiver keeps up.
// The result path runs through the square root pipeline (one root bit per
// stage) and the normal divider pipeline (one quotient bit per stage).
// A front register feeds a four-entry queue that feeds the arithmetic
// pipeline; when rsp_ready is low the pipeline holds in place, the queue fills,
// and req_ready drops once queue and front register are full.
// Synchronous reset empties the pipeline, queue and front register; no result
// is valid after reset until a new triangle arrives.
module triangle_normal_area_centroid #(
   parameter int COORD_WIDTH      = tnac_pkg::COORD_WIDTH_DEF,
   parameter int NORMAL_FRAC_BITS = tnac_pkg::NORMAL_FRAC_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic signed [COORD_WIDTH-1:0]      req_vertex_a_x,
   input  logic signed [COORD_WIDTH-1:0]      req_vertex_a_y,
   input  logic signed [COORD_WIDTH-1:0]      req_vertex_a_z,
   input  logic signed [COORD_WIDTH-1:0]      req_vertex_b_x,
   input  logic signed [COORD_WIDTH-1:0]      req_vertex_b_y,
   input  logic signed [COORD_WIDTH-1:0]      req_vertex_b_z,
   input  logic signed [COORD_WIDTH-1:0]      req_vertex_c_x,
   input  logic signed [COORD_WIDTH-1:0]      req_vertex_c_y,
   input  logic signed [COORD_WIDTH-1:0]      req_vertex_c_z,
   input  logic                               req_last_in_mesh,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [NORMAL_FRAC_BITS:0]   rsp_normal_x,
   output logic signed [NORMAL_FRAC_BITS:0]   rsp_normal_y,
   output logic signed [NORMAL_FRAC_BITS:0]   rsp_normal_z,
   output logic [tnac_pkg::AREA_WIDTH-1:0]    rsp_double_area,
   output logic signed [COORD_WIDTH-1:0]      rsp_centroid_x,
   output logic signed [COORD_WIDTH-1:0]      rsp_centroid_y,
   output logic signed [COORD_WIDTH-1:0]      rsp_centroid_z,
   output logic                               rsp_degenerate,
   output logic                               rsp_last_out
);
   localparam int QDW = 6 * (COORD_WIDTH + 1) + 3 * (COORD_WIDTH + 3) + 1;

   logic           f_valid, f_ready;
   logic [QDW-1:0] f_data;
   logic           q_valid, q_ready;
   logic [QDW-1:0] q_data;

   tnac_front #(.CW(COORD_WIDTH)) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_vertex_a_x   (req_vertex_a_x),
      .req_vertex_a_y   (req_vertex_a_y),
      .req_vertex_a_z   (req_vertex_a_z),
      .req_vertex_b_x   (req_vertex_b_x),
      .req_vertex_b_y   (req_vertex_b_y),
      .req_vertex_b_z   (req_vertex_b_z),
      .req_vertex_c_x   (req_vertex_c_x),
      .req_vertex_c_y   (req_vertex_c_y),
      .req_vertex_c_z   (req_vertex_c_z),
      .req_last_in_mesh (req_last_in_mesh),
      .out_valid        (f_valid),
      .out_ready        (f_ready),
      .out_data         (f_data)
   );

   tnac_queue #(.DW(QDW)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_data   (f_data),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_data  (q_data)
   );

   tnac_back #(.CW(COORD_WIDTH), .NF(NORMAL_FRAC_BITS)) u_back (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (q_valid),
      .in_ready        (q_ready),
      .in_data         (q_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_normal_x    (rsp_normal_x),
      .rsp_normal_y    (rsp_normal_y),
      .rsp_normal_z    (rsp_normal_z),
      .rsp_double_area (rsp_double_area),
      .rsp_centroid_x  (rsp_centroid_x),
      .rsp_centroid_y  (rsp_centroid_y),
      .rsp_centroid_z  (rsp_centroid_z),
      .rsp_degenerate  (rsp_degenerate),
      .rsp_last_out    (rsp_last_out)
   );
endmodule
